// ----- hdl/wall_follow_pd_sequencer_core_defines.svh -----
// Assertion macros for the wall follow PD sequencer.
`ifndef WALL_FOLLOW_PD_SEQUENCER_CORE_DEFINES_SVH
`define WALL_FOLLOW_PD_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WFPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define WFPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WFPD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WFPD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/wfpd_pkg.sv -----
package wfpd_pkg;

    localparam int DIST_W   = 14;
    localparam int GAIN_W   = 12;
    localparam int CMD_W    = 16;
    localparam int ERR_W    = DIST_W + 1;
    localparam int LAST_W   = 16;
    localparam int STATUS_W = 4;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [4:0] {
        PH_GROUND   = 5'b00001,
        PH_TAKEOFF  = 5'b00010,
        PH_HOVER    = 5'b00100,
        PH_APPROACH = 5'b01000,
        PH_TRACK    = 5'b10000
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_KD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_KP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_KP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SPEED  = 3'd6;

    localparam logic KIND_TAKEOFF  = 1'b0;
    localparam logic KIND_VELOCITY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_FLYING   = 4'd3;
    localparam logic [STATUS_W-1:0] STATUS_HOVERING = 4'd7;

    localparam logic [GAIN_W-1:0]        RST_APPROACH_KP = 12'd307;
    localparam logic [GAIN_W-1:0]        RST_SHARED_KD   = 12'd56;
    localparam logic [GAIN_W-1:0]        RST_TRACK_KP    = 12'd128;
    localparam logic [GAIN_W-1:0]        RST_YAW_KP      = 12'd384;
    localparam logic [DIST_W-1:0]        RST_TARGET      = 14'd1200;
    localparam logic [DIST_W-1:0]        RST_TOLERANCE   = 14'd10;
    localparam logic signed [CMD_W-1:0] RST_SIDE_SPEED  = 16'sd500;
    localparam logic signed [LAST_W-1:0] RST_LAST_ERR   = 16'sd340;

endpackage

// ----- hdl/wfpd_calc.sv -----
// PD forward term and P yaw term, fixed point gains, floor shift, 16 bit clamp.
module wfpd_calc #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic signed [wfpd_pkg::ERR_W-1:0]  i_err,
    input  logic signed [wfpd_pkg::LAST_W-1:0] i_last_err,
    input  logic        [wfpd_pkg::GAIN_W-1:0] i_kp,
    input  logic        [wfpd_pkg::GAIN_W-1:0] i_kd,
    input  logic        [wfpd_pkg::GAIN_W-1:0] i_yaw_kp,
    input  logic        [wfpd_pkg::DIST_W-1:0] i_left,
    input  logic        [wfpd_pkg::DIST_W-1:0] i_right,
    output logic signed [wfpd_pkg::CMD_W-1:0]  o_forward,
    output logic signed [wfpd_pkg::CMD_W-1:0]  o_yaw
);

    localparam int DIFF_W = wfpd_pkg::LAST_W + 1;
    localparam int P_W    = wfpd_pkg::ERR_W + wfpd_pkg::GAIN_W + 1;
    localparam int D_W    = DIFF_W + wfpd_pkg::GAIN_W + 1;
    localparam int SUM_W  = D_W + 1;

    function automatic logic signed [wfpd_pkg::CMD_W-1:0] sat16(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [wfpd_pkg::CMD_W-1:0] r;
        if (v > SUM_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -SUM_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[wfpd_pkg::CMD_W-1:0];
        end
        return r;
    endfunction

    logic signed [DIFF_W-1:0]         diff;
    logic signed [P_W-1:0]            prod_p;
    logic signed [D_W-1:0]            prod_d;
    logic signed [SUM_W-1:0]          pd_sum;
    logic signed [SUM_W-1:0]          pd_shift;
    logic signed [wfpd_pkg::ERR_W-1:0] lr_diff;
    logic signed [P_W-1:0]            prod_y;
    logic signed [P_W-1:0]            y_shift;

    assign diff   = {{2{i_err[wfpd_pkg::ERR_W-1]}}, i_err}
                  - {i_last_err[wfpd_pkg::LAST_W-1], i_last_err};
    assign prod_p = i_err * $signed({1'b0, i_kp});
    assign prod_d = diff * $signed({1'b0, i_kd});
    assign pd_sum = {{(SUM_W-P_W){prod_p[P_W-1]}}, prod_p} + {prod_d[D_W-1], prod_d};
    // arithmetic shift gives the floor toward minus infinity
    assign pd_shift = pd_sum >>> GAIN_FRAC_BITS;

    // yaw = -(left - right) * gain
    assign lr_diff = $signed({1'b0, i_right}) - $signed({1'b0, i_left});
    assign prod_y  = lr_diff * $signed({1'b0, i_yaw_kp});
    assign y_shift = prod_y >>> GAIN_FRAC_BITS;

    assign o_forward = sat16(pd_shift);
    assign o_yaw     = sat16({{(SUM_W-P_W){y_shift[P_W-1]}}, y_shift});

endmodule

// ----- hdl/wall_follow_pd_sequencer_core.sv -----
// Wall follow PD sequencer.
// Input stream (s_axis): one sensor word per update: front, left and right
// distances in mm and the vehicle's flight status. Output stream (m_axis):
// at most one command word per sensor word; tuser tells a takeoff request
// from a velocity command. The config channel writes gain, target,
// tolerance and side speed registers; write them only while no word is
// in flight.
// A word accepted into the input register moves on to the result register
// and leaves m_axis from there. Throughput: one word per cycle unless
// m_axis stalls; the phase and last error update in the single compute
// stage, so back-to-back words see each other's state.
// Words in the taking off and hovering phases produce no command.
// Reset: phase goes to on ground, last error to 340 mm, registers to their
// defaults, both pipeline registers empty.
// Stall: while m_axis_tready is low the result register holds its word and
// the input register fills; s_axis_tready drops once both are full.
`include "wall_follow_pd_sequencer_core_defines.svh"

module wall_follow_pd_sequencer_core #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // front_distance[13:0], left_distance[27:14], right_distance[41:28],
    // flight_status[45:42], zero fill [47:46]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // forward_cmd[15:0], sideways_cmd[31:16], yaw_cmd[47:32]
    output logic [47:0] m_axis_tdata,
    // command_kind[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DW = wfpd_pkg::DIST_W;
    localparam int GW = wfpd_pkg::GAIN_W;
    localparam int CW = wfpd_pkg::CMD_W;

    // config registers
    logic        [GW-1:0] r_approach_kp, r_shared_kd, r_track_kp, r_yaw_kp;
    logic        [DW-1:0] r_target, r_tolerance;
    logic signed [CW-1:0] r_side_speed;

    // input register
    logic                               r_in_valid;
    logic [DW-1:0]                      r_front, r_left, r_right;
    logic [wfpd_pkg::STATUS_W-1:0]      r_status;

    // sequencer state
    wfpd_pkg::t_phase                   r_phase, n_phase;
    logic signed [wfpd_pkg::LAST_W-1:0] r_last_err, n_last_err;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic                 r_kind, n_kind;
    logic signed [CW-1:0] r_fwd, n_fwd, r_side, n_side, r_yaw, n_yaw;

    logic                              advance;
    logic signed [wfpd_pkg::ERR_W-1:0] err;
    logic        [GW-1:0]              sel_kp;
    logic signed [CW-1:0]              calc_fwd, calc_yaw;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_yaw, r_side, r_fwd};
    assign m_axis_tuser  = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_approach_kp <= wfpd_pkg::RST_APPROACH_KP;
            r_shared_kd   <= wfpd_pkg::RST_SHARED_KD;
            r_track_kp    <= wfpd_pkg::RST_TRACK_KP;
            r_yaw_kp      <= wfpd_pkg::RST_YAW_KP;
            r_target      <= wfpd_pkg::RST_TARGET;
            r_tolerance   <= wfpd_pkg::RST_TOLERANCE;
            r_side_speed  <= wfpd_pkg::RST_SIDE_SPEED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wfpd_pkg::CFG_APPROACH_KP: r_approach_kp <= i_cfg_data[GW-1:0];
                wfpd_pkg::CFG_SHARED_KD:   r_shared_kd   <= i_cfg_data[GW-1:0];
                wfpd_pkg::CFG_TRACK_KP:    r_track_kp    <= i_cfg_data[GW-1:0];
                wfpd_pkg::CFG_YAW_KP:      r_yaw_kp      <= i_cfg_data[GW-1:0];
                wfpd_pkg::CFG_TARGET:      r_target      <= i_cfg_data[DW-1:0];
                wfpd_pkg::CFG_TOLERANCE:   r_tolerance   <= i_cfg_data[DW-1:0];
                wfpd_pkg::CFG_SIDE_SPEED:  r_side_speed  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_front  <= s_axis_tdata[13:0];
            r_left   <= s_axis_tdata[27:14];
            r_right  <= s_axis_tdata[41:28];
            r_status <= s_axis_tdata[45:42];
        end
    end

    assign err    = $signed({1'b0, r_front}) - $signed({1'b0, r_target});
    assign sel_kp = (r_phase == wfpd_pkg::PH_TRACK) ? r_track_kp : r_approach_kp;

    wfpd_calc #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .i_err      (err),
        .i_last_err (r_last_err),
        .i_kp       (sel_kp),
        .i_kd       (r_shared_kd),
        .i_yaw_kp   (r_yaw_kp),
        .i_left     (r_left),
        .i_right    (r_right),
        .o_forward  (calc_fwd),
        .o_yaw      (calc_yaw)
    );

    always_comb begin
        n_phase     = r_phase;
        n_last_err  = r_last_err;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_kind      = r_kind;
        n_fwd       = r_fwd;
        n_side      = r_side;
        n_yaw       = r_yaw;
        if (advance) begin
            unique case (r_phase)
                wfpd_pkg::PH_GROUND: begin
                    n_out_valid = 1'b1;
                    n_kind      = wfpd_pkg::KIND_TAKEOFF;
                    n_fwd       = '0;
                    n_side      = '0;
                    n_yaw       = '0;
                    n_phase     = wfpd_pkg::PH_TAKEOFF;
                end
                wfpd_pkg::PH_TAKEOFF: begin
                    if (r_status == wfpd_pkg::STATUS_FLYING ||
                        r_status == wfpd_pkg::STATUS_HOVERING) begin
                        n_phase = wfpd_pkg::PH_HOVER;
                    end
                end
                wfpd_pkg::PH_HOVER: begin
                    n_phase = wfpd_pkg::PH_APPROACH;
                end
                wfpd_pkg::PH_APPROACH: begin
                    n_out_valid = 1'b1;
                    n_kind      = wfpd_pkg::KIND_VELOCITY;
                    n_fwd       = calc_fwd;
                    n_side      = '0;
                    n_yaw       = '0;
                    n_last_err  = wfpd_pkg::LAST_W'(err);
                    // negative error (too close) also ends the approach
                    if (err < $signed({1'b0, r_tolerance})) begin
                        n_phase = wfpd_pkg::PH_TRACK;
                    end
                end
                wfpd_pkg::PH_TRACK: begin
                    n_out_valid = 1'b1;
                    n_kind      = wfpd_pkg::KIND_VELOCITY;
                    n_fwd       = calc_fwd;
                    n_side      = r_side_speed;
                    n_yaw       = calc_yaw;
                    n_last_err  = wfpd_pkg::LAST_W'(err);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wfpd_pkg::PH_GROUND;
            r_last_err  <= wfpd_pkg::RST_LAST_ERR;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_last_err  <= n_last_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_fwd  <= n_fwd;
        r_side <= n_side;
        r_yaw  <= n_yaw;
    end

    `WFPD_ASSERT_IMP(a_takeoff_zero, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[0] == wfpd_pkg::KIND_TAKEOFF),
        m_axis_tdata == '0)
    `WFPD_ASSERT_NXT(a_ground_step, i_clk, i_rst_n,
        advance && (r_phase == wfpd_pkg::PH_GROUND),
        (r_phase == wfpd_pkg::PH_TAKEOFF) && r_out_valid)
    `WFPD_ASSERT_NXT(a_approach_no_side, i_clk, i_rst_n,
        advance && (r_phase == wfpd_pkg::PH_APPROACH),
        r_out_valid && (m_axis_tdata[47:16] == '0))

endmodule
